@@ rtl/lhb_pkg.sv @@
// Shared constants and codes for the luminance histogram bimodality scorer.
// No dependencies; all rtl/ files but lhb_div.sv refer to this package by scoped name.
package lhb_pkg;

  localparam int LUMA_W     = 8;
  localparam int CNT_W      = 21;
  localparam int SD_W       = 5;
  localparam int PCT_W      = 7;
  localparam int SCORE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [SCORE_W-1:0] Q15_ONE       = 16'd32768;
  localparam logic [PCT_W-1:0]   PERCENT_SCALE = 7'd100;
  localparam logic [SD_W-1:0]    SD_RESET      = 5'd6;
  localparam logic [PCT_W-1:0]   PCT_RESET     = 7'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHOULDER_DIST = 2'd0,
    REG_MIN_PEAK_PCT  = 2'd1
  } cfg_reg_t;

endpackage

@@ rtl/lhb_if.sv @@
// Channel interfaces of the bimodality scorer: pixel input, score output, register writes.
// Depends on lhb_pkg for field widths.
interface lhb_in_if;
  logic                       valid;
  logic                       ready;
  logic [lhb_pkg::LUMA_W-1:0] pixel_luma;
  logic                       frame_end;
  modport source (output valid, pixel_luma, frame_end, input ready);
  modport sink   (input valid, pixel_luma, frame_end, output ready);
endinterface

interface lhb_out_if;
  logic                        valid;
  logic                        ready;
  logic [lhb_pkg::SCORE_W-1:0] shadow_score;
  logic                        peak_too_weak;
  modport source (output valid, shadow_score, peak_too_weak, input ready);
  modport sink   (input valid, shadow_score, peak_too_weak, output ready);
endinterface

interface lhb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lhb_pkg::CFG_IDX_W-1:0]  index;
  logic [lhb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lhb_front.sv @@
// Front end: accept pixel words, map luminance to a bin and queue them for the back end.
// Depends on lhb_pkg and lhb_in_if.
module lhb_front #(
  parameter int NUM_BINS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lhb_in_if.sink                      in_pix,
  output logic                        q_valid_o,
  output logic [$clog2(NUM_BINS)-1:0] q_bin_o,
  output logic                        q_last_o,
  input  logic                        q_take_i
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int PROD_W = lhb_pkg::LUMA_W + BIN_W + 1;
  localparam int ITEM_W = BIN_W + 1;
  localparam int DEPTH  = 4;
  localparam int PTR_W  = $clog2(DEPTH);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] raw_bin;
  logic [BIN_W-1:0]  bin;
  logic              push;
  logic              pop;

  logic [ITEM_W-1:0] queue_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W:0]    cnt_r;

  // bin = (luma * NUM_BINS) >> 8, clamped to the top bin
  assign prod    = PROD_W'(in_pix.pixel_luma) * PROD_W'(NUM_BINS);
  assign raw_bin = prod >> lhb_pkg::LUMA_W;
  assign bin     = (raw_bin > PROD_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                     : raw_bin[BIN_W-1:0];

  assign in_pix.ready = (cnt_r != (PTR_W+1)'(DEPTH));
  assign push         = in_pix.valid && in_pix.ready;
  assign pop          = q_take_i && q_valid_o;

  assign q_valid_o = (cnt_r != '0);
  assign q_bin_o   = queue_r[rd_ptr_r][BIN_W:1];
  assign q_last_o  = queue_r[rd_ptr_r][0];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= {bin, in_pix.frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      priority if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push)     cnt_r <= cnt_r - 1'b1;
      else                       cnt_r <= cnt_r;
    end
  end

endmodule

@@ rtl/lhb_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, dividend below divisor.
// Depends on nothing; instantiated by lhb_back.
module lhb_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 27,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int CNT_W = $clog2(Q_W);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           fits;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r  <= DEN_W'(dividend_i);
      den_r  <= divisor_i;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot_r <= {quot_r[Q_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

@@ rtl/lhb_back.sv @@
// Back end: histogram lanes, end-of-frame peak/valley scan, score and result register.
// Depends on lhb_pkg and lhb_div.
module lhb_back #(
  parameter int NUM_BINS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid_i,
  input  logic [$clog2(NUM_BINS)-1:0]  q_bin_i,
  input  logic                         q_last_i,
  output logic                         q_take_o,
  input  logic [lhb_pkg::SD_W-1:0]     sd_i,
  input  logic [lhb_pkg::PCT_W-1:0]    pct_i,
  output logic                         out_valid_o,
  output logic [lhb_pkg::SCORE_W-1:0]  out_score_o,
  output logic                         out_weak_o,
  input  logic                         out_ready_i
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int CNT_W  = lhb_pkg::CNT_W;
  localparam int DIST_W = (BIN_W > lhb_pkg::SD_W) ? BIN_W : lhb_pkg::SD_W;
  localparam int PRD_W  = CNT_W + lhb_pkg::PCT_W;
  localparam int NUM_W  = CNT_W + BIN_W;
  localparam int DEN_W  = CNT_W + BIN_W + 1;
  localparam int Q_W    = lhb_pkg::SCORE_W;

  typedef enum logic [9:0] {
    ST_RUN    = 10'b0000000001,
    ST_PEAK1  = 10'b0000000010,
    ST_PEAK2  = 10'b0000000100,
    ST_SPAN   = 10'b0000001000,
    ST_VALLEY = 10'b0000010000,
    ST_CHECK  = 10'b0000100000,
    ST_DECIDE = 10'b0001000000,
    ST_PREP   = 10'b0010000000,
    ST_DIV    = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] hist_r [NUM_BINS];
  logic [CNT_W-1:0] total_r;
  logic [BIN_W-1:0] idx_r;
  logic [CNT_W-1:0] max1_r;
  logic [BIN_W-1:0] p1_r;
  logic [CNT_W-1:0] p2max_r;
  logic [BIN_W-1:0] p2_r;
  logic             found_r;
  logic [BIN_W-1:0] lo_r;
  logic [BIN_W-1:0] hi_r;
  logic [CNT_W-1:0] pmin_r;
  logic [CNT_W-1:0] valley_r;
  logic [PRD_W-1:0] prod_a_r;
  logic [PRD_W-1:0] prod_b_r;
  logic [Q_W-1:0]   res_score_r;
  logic             res_weak_r;
  logic             out_valid_r;
  logic [Q_W-1:0]   out_score_r;
  logic             out_weak_r;

  logic [CNT_W-1:0] rd;
  logic             last_idx;
  logic [BIN_W-1:0] gap;
  logic             eligible;
  logic             better2;
  logic [BIN_W-1:0] lo;
  logic [BIN_W-1:0] hi;
  logic             take;
  logic             emit_fire;
  logic             clear;
  logic             div_start;
  logic             div_done;
  logic [Q_W-1:0]   div_quot;
  logic [NUM_W-1:0] dividend;
  logic [DEN_W-1:0] divisor;

  assign rd       = hist_r[idx_r];
  assign last_idx = (idx_r == BIN_W'(NUM_BINS - 1));
  assign gap      = (idx_r > p1_r) ? (idx_r - p1_r) : (p1_r - idx_r);
  assign eligible = (DIST_W'(gap) >= DIST_W'(sd_i));
  assign better2  = eligible && (!found_r || (rd > p2max_r));
  assign lo       = (p1_r < p2_r) ? p1_r : p2_r;
  assign hi       = (p1_r < p2_r) ? p2_r : p1_r;

  assign take      = (state_r == ST_RUN) && q_valid_i;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready_i);
  assign clear     = emit_fire;
  assign q_take_o  = take;

  // valley never exceeds pmin, and (pmin - valley) * sep < pmin * NUM_BINS
  assign div_start = (state_r == ST_PREP);
  assign dividend  = NUM_W'(pmin_r - valley_r) * NUM_W'(hi_r - lo_r);
  assign divisor   = DEN_W'(pmin_r) * DEN_W'(NUM_BINS);

  lhb_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:    if (take && q_last_i) state_nxt = ST_PEAK1;
      ST_PEAK1:  if (last_idx) state_nxt = ST_PEAK2;
      ST_PEAK2:  if (last_idx) state_nxt = (found_r || better2) ? ST_SPAN : ST_EMIT;
      ST_SPAN:   state_nxt = ST_VALLEY;
      ST_VALLEY: if (idx_r == hi_r) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if ((prod_a_r < prod_b_r) || (pmin_r == '0)) state_nxt = ST_EMIT;
        else                                         state_nxt = ST_PREP;
      end
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (emit_fire) state_nxt = ST_RUN;
      default:   state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_RUN;
    else        state_r <= state_nxt;
  end

  // Histogram lanes: each bin owns a saturating incrementer
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < NUM_BINS; i++) hist_r[i] <= '0;
      total_r <= '0;
    end else if (take) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        if ((q_bin_i == BIN_W'(i)) && (hist_r[i] != lhb_pkg::CNT_MAX)) begin
          hist_r[i] <= hist_r[i] + 1'b1;
        end
      end
      if (total_r != lhb_pkg::CNT_MAX) total_r <= total_r + 1'b1;
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_RUN: begin
        idx_r       <= '0;
        max1_r      <= '0;
        p1_r        <= '0;
        found_r     <= 1'b0;
        p2max_r     <= '0;
        p2_r        <= '0;
        res_score_r <= '0;
        res_weak_r  <= 1'b0;
      end
      ST_PEAK1: begin
        if (rd > max1_r) begin
          max1_r <= rd;
          p1_r   <= idx_r;
        end
        idx_r <= last_idx ? '0 : idx_r + 1'b1;
      end
      ST_PEAK2: begin
        if (better2) begin
          p2max_r <= rd;
          p2_r    <= idx_r;
          found_r <= 1'b1;
        end
        idx_r <= last_idx ? '0 : idx_r + 1'b1;
      end
      ST_SPAN: begin
        lo_r     <= lo;
        hi_r     <= hi;
        idx_r    <= lo;
        pmin_r   <= (max1_r < p2max_r) ? max1_r : p2max_r;
        valley_r <= lhb_pkg::CNT_MAX;
      end
      ST_VALLEY: begin
        if (rd < valley_r) valley_r <= rd;
        idx_r <= idx_r + 1'b1;
      end
      ST_CHECK: begin
        prod_a_r <= PRD_W'(pmin_r) * PRD_W'(lhb_pkg::PERCENT_SCALE);
        prod_b_r <= PRD_W'(total_r) * PRD_W'(pct_i);
      end
      ST_DECIDE: begin
        if (prod_a_r < prod_b_r) res_weak_r <= 1'b1;
      end
      ST_PREP: begin
        res_score_r <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          res_score_r <= (div_quot > lhb_pkg::Q15_ONE) ? lhb_pkg::Q15_ONE : div_quot;
        end
      end
      ST_EMIT: begin
        idx_r <= '0;
      end
      default: begin
        idx_r <= '0;
      end
    endcase
  end

  // Result register: hold the score until the sink takes it
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_score_r <= res_score_r;
      out_weak_r  <= res_weak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (emit_fire)  out_valid_r <= 1'b1;
    else if (out_ready_i) out_valid_r <= 1'b0;
  end

  assign out_valid_o = out_valid_r;
  assign out_score_o = out_score_r;
  assign out_weak_o  = out_weak_r;

endmodule

@@ rtl/luminance_histogram_bimodality.sv @@
// Luminance histogram bimodality scorer: pixels in, one Q1.15 shadow score per frame out.
// Depends on lhb_pkg, the lhb_*_if interfaces, lhb_front, lhb_back and lhb_div.
//
// Feed one 8-bit luminance pixel per word; each pixel lands in one of NUM_BINS bins
// ((luma * NUM_BINS) >> 8) and the pixel count, all counters saturating at 2^21-1. The
// word carrying frame_end is counted and then closes the frame: the block finds the main
// peak (lowest index among ties), the strongest bin at least shoulder_distance away,
// the deepest valley between them, and returns one result word holding
// min(32768, floor(65536 * (1 - valley/pmin) * sep / NUM_BINS)) with pmin the smaller
// peak and sep the peak distance. When pmin * 100 < pixels * min_peak_percent the score
// is zero and peak_too_weak is set; else, with no qualifying second peak or an empty
// smaller peak, both are zero. The histogram and pixel count then clear for the next
// frame. Rate: pixels are binned at one per cycle outside the frame-end scan and its
// result hand-off. The frame-end word costs a scan of the histogram through its single
// read index: two peak passes, the valley pass, the percentage check and a serial
// divider. A four-word queue keeps taking pixels during the scan until it fills; the
// result register lets the next frame start while a score waits for the sink. Reset
// clears the histogram at once: no start-up sweep.
// Registers may be written whenever no frame is in flight; index 0 is shoulder_distance
// (reset 6), index 1 is min_peak_percent (reset 2); other indices are ignored.
module luminance_histogram_bimodality #(
  parameter int NUM_BINS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lhb_in_if.sink     in_pix,
  lhb_out_if.source  out_res,
  lhb_cfg_if.sink    cfg_wr
);

  localparam int BIN_W = $clog2(NUM_BINS);

  logic [lhb_pkg::SD_W-1:0]  sd_r;
  logic [lhb_pkg::PCT_W-1:0] pct_r;

  logic             q_valid;
  logic [BIN_W-1:0] q_bin;
  logic             q_last;
  logic             q_take;

  // Register writes are always taken
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r  <= lhb_pkg::SD_RESET;
      pct_r <= lhb_pkg::PCT_RESET;
    end else if (cfg_wr.valid) begin
      priority if (cfg_wr.index == lhb_pkg::REG_SHOULDER_DIST) begin
        sd_r <= cfg_wr.data[lhb_pkg::SD_W-1:0];
      end else if (cfg_wr.index == lhb_pkg::REG_MIN_PEAK_PCT) begin
        pct_r <= cfg_wr.data[lhb_pkg::PCT_W-1:0];
      end else begin
        // drop writes to unmapped indices
        sd_r <= sd_r;
      end
    end
  end

  // Front: bin the pixel and queue it
  lhb_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .q_valid_o (q_valid),
    .q_bin_o   (q_bin),
    .q_last_o  (q_last),
    .q_take_i  (q_take)
  );

  // Back: count, evaluate on frame end, hold the result
  lhb_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_bin_i     (q_bin),
    .q_last_i    (q_last),
    .q_take_o    (q_take),
    .sd_i        (sd_r),
    .pct_i       (pct_r),
    .out_valid_o (out_res.valid),
    .out_score_o (out_res.shadow_score),
    .out_weak_o  (out_res.peak_too_weak),
    .out_ready_i (out_res.ready)
  );

endmodule

@@ rtl/lhb_checker.sv @@
// Port-level checks on the scorer's result channel, bound to the top level.
// Depends on lhb_pkg and luminance_histogram_bimodality.
module lhb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lhb_pkg::SCORE_W-1:0] shadow_score,
  input logic                        peak_too_weak
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(shadow_score) && $stable(peak_too_weak))
    else $error("result word changed while stalled");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> shadow_score <= lhb_pkg::Q15_ONE)
    else $error("score above 1.0");

  a_weak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && peak_too_weak |-> shadow_score == '0)
    else $error("weak peak with non-zero score");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind luminance_histogram_bimodality lhb_checker u_lhb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .shadow_score  (out_res.shadow_score),
  .peak_too_weak (out_res.peak_too_weak)
);

@@ tb/luminance_histogram_bimodality_tb.sv @@
// Self-checking testbench for the luminance histogram bimodality scorer.
// Depends on lhb_pkg, the lhb_*_if interfaces and the luminance_histogram_bimodality top.
`timescale 1ns / 100ps

module luminance_histogram_bimodality_tb;

  localparam int HIST_BINS       = 32;
  localparam int BIN_SPAN        = (1 << lhb_pkg::LUMA_W) / HIST_BINS;
  // Worst frame-end scan plus the serial divide, with margin for the output register.
  localparam int EVAL_SETTLE     = 3 * HIST_BINS + 30;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int IDLE_PERCENT    = 31;
  localparam int RANDOM_PIXELS   = 1150;
  localparam int RANDOM_PHASES   = 8;
  localparam int HOLD_OFF_CYCLES = 500;

  // Indices past the register map; writes to them must leave the settings alone.
  localparam logic [lhb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [lhb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum {FRAME_TWO_HUMPS, FRAME_ONE_HUMP, FRAME_NOISE, FRAME_EXTREMES} frame_shape_t;

  typedef struct packed {
    logic [lhb_pkg::SCORE_W-1:0] score;
    logic                        too_weak;
  } frame_score_t;

  logic clk = 1'b0;
  logic rst_n;

  lhb_in_if  pix_if ();
  lhb_out_if res_if ();
  lhb_cfg_if cfg_if ();

  luminance_histogram_bimodality #(.NUM_BINS(HIST_BINS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  // Shadow histogram and settings, advanced on every accepted word.
  logic [lhb_pkg::CNT_W-1:0] hist_count [HIST_BINS];
  logic [lhb_pkg::CNT_W-1:0] frame_pixels;
  logic [lhb_pkg::SD_W-1:0]  shoulder_cfg;
  logic [lhb_pkg::PCT_W-1:0] min_pct_cfg;
  frame_score_t              pending_scores [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int hold_req    = 0;
  int hold_left   = 0;
  bit steady_flow = 1'b0;

  always #2 clk = ~clk;

  // Hard stop if the block wedges.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Bin one pixel; on the frame's closing word score the histogram, queue the
  // expected result word and clear the histogram for the next frame.
  task automatic tally_pixel(input logic [lhb_pkg::LUMA_W-1:0] luma, input logic closes);
    int unsigned       bin, peak, rival, lo, hi, gap;
    bit                has_rival;
    longint unsigned   pmin, valley, quot;
    frame_score_t      res;
    bin = (32'(luma) * HIST_BINS) >> lhb_pkg::LUMA_W;
    if (bin > HIST_BINS - 1) bin = HIST_BINS - 1;
    if (hist_count[bin] != lhb_pkg::CNT_MAX) hist_count[bin]++;
    if (frame_pixels != lhb_pkg::CNT_MAX) frame_pixels++;
    if (!closes) return;

    res  = '0;
    // Main peak: strict greater-than keeps the lowest index among ties.
    peak = 0;
    for (int i = 1; i < HIST_BINS; i++)
      if (hist_count[i] > hist_count[peak]) peak = i;
    // Second peak: strongest bin at least the shoulder distance away.
    has_rival = 1'b0;
    rival     = 0;
    for (int i = 0; i < HIST_BINS; i++) begin
      gap = (i > peak) ? i - peak : peak - i;
      if (gap >= shoulder_cfg && (!has_rival || hist_count[i] > hist_count[rival])) begin
        rival     = i;
        has_rival = 1'b1;
      end
    end
    if (has_rival) begin
      lo = (peak < rival) ? peak : rival;
      hi = (peak < rival) ? rival : peak;
      valley = hist_count[lo];
      for (int i = lo; i <= hi; i++)
        if (hist_count[i] < valley) valley = hist_count[i];
      pmin = (hist_count[peak] < hist_count[rival]) ? hist_count[peak] : hist_count[rival];
      if (pmin * 64'(lhb_pkg::PERCENT_SCALE) < 64'(frame_pixels) * 64'(min_pct_cfg)) begin
        res.too_weak = 1'b1;
      end else if (pmin != 0) begin
        quot = (64'd2 * 64'(lhb_pkg::Q15_ONE) * (pmin - valley) * 64'(hi - lo)) /
               (pmin * 64'(HIST_BINS));
        if (quot > 64'(lhb_pkg::Q15_ONE)) quot = 64'(lhb_pkg::Q15_ONE);
        res.score = quot[lhb_pkg::SCORE_W-1:0];
      end
    end
    pending_scores.push_back(res);
    foreach (hist_count[i]) hist_count[i] = '0;
    frame_pixels = '0;
  endtask

  // Offer one pixel word, idling first at random unless the flow is steady.
  task automatic send_pixel(input logic [lhb_pkg::LUMA_W-1:0] luma, input logic closes);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      pix_if.valid = 1'b0;
      @(negedge clk);
    end
    pix_if.valid      = 1'b1;
    pix_if.pixel_luma = luma;
    pix_if.frame_end  = closes;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    tally_pixel(luma, closes);
    @(negedge clk);
    pix_if.valid = 1'b0;
  endtask

  task automatic cfg_write(input logic [lhb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lhb_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      lhb_pkg::REG_SHOULDER_DIST: shoulder_cfg = data[lhb_pkg::SD_W-1:0];
      lhb_pkg::REG_MIN_PEAK_PCT:  min_pct_cfg  = data[lhb_pkg::PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Wait for every queued score, then let any scan still running settle.
  task automatic drain_scores();
    pix_if.valid = 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (EVAL_SETTLE) @(negedge clk);
  endtask

  // One frame of len pixels, the final word carrying frame_end.
  task automatic send_frame(input frame_shape_t shape, input int len);
    int                         hump_a, hump_b, spread, share, centre, b;
    logic [lhb_pkg::LUMA_W-1:0] luma;
    hump_a = $urandom_range(HIST_BINS - 1);
    hump_b = $urandom_range(HIST_BINS - 1);
    spread = $urandom_range(3);
    share  = $urandom_range(10, 90);
    for (int n = 0; n < len; n++) begin
      case (shape)
        FRAME_TWO_HUMPS, FRAME_ONE_HUMP: begin
          centre = (shape == FRAME_TWO_HUMPS && $urandom_range(99) < share) ? hump_b : hump_a;
          if ($urandom_range(9) == 0) begin
            luma = lhb_pkg::LUMA_W'($urandom);
          end else begin
            b = centre + int'($urandom_range(2 * spread)) - spread;
            if (b < 0) b = 0;
            if (b > HIST_BINS - 1) b = HIST_BINS - 1;
            luma = lhb_pkg::LUMA_W'(b * BIN_SPAN + int'($urandom_range(BIN_SPAN - 1)));
          end
        end
        FRAME_NOISE: luma = lhb_pkg::LUMA_W'($urandom);
        default: begin
          case ($urandom_range(2))
            0:       luma = '0;
            1:       luma = '1;
            default: luma = lhb_pkg::LUMA_W'(hump_a * BIN_SPAN);
          endcase
        end
      endcase
      send_pixel(luma, n == len - 1);
    end
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Compare every delivered score word with the oldest expectation.
  always @(posedge clk) begin
    frame_score_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unexpected score word, shadow_score", res_if.shadow_score, 0);
      end else begin
        want = pending_scores.pop_front();
        if (res_if.shadow_score !== want.score)
          report_mismatch("shadow_score", res_if.shadow_score, want.score);
        if (res_if.peak_too_weak !== want.too_weak)
          report_mismatch("peak_too_weak", res_if.peak_too_weak, want.too_weak);
      end
    end
  end

  // Reset settings: a wide two-sided frame saturates the score, a narrow one does not.
  task automatic test_reset_defaults();
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'd80, 1'b0);
    send_pixel(8'd128, 1'b1);
    drain_scores();
  endtask

  // Writes past the register map must be dropped.
  task automatic test_spare_registers();
    cfg_write(REG_SPARE_LO, 7'h7F);
    cfg_write(REG_SPARE_HI, 7'h55);
    send_pixel(8'd80, 1'b0);
    send_pixel(8'd80, 1'b0);
    send_pixel(8'd128, 1'b1);
    drain_scores();
  endtask

  task automatic test_shoulder_extremes();
    // Bit 5 of the data falls outside the field: shoulder becomes zero, so the
    // second peak lands on the main one and the separation vanishes.
    cfg_write(lhb_pkg::REG_SHOULDER_DIST, 7'h20);
    cfg_write(lhb_pkg::REG_MIN_PEAK_PCT, 7'd0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    drain_scores();

    // Widest shoulder: a mid-range peak has no partner, an edge peak does.
    cfg_write(lhb_pkg::REG_SHOULDER_DIST, 7'h7F);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    drain_scores();

    // Narrowest shoulder: an empty smaller peak with no percentage floor, then
    // a shallow valley that gives a small non-zero score.
    cfg_write(lhb_pkg::REG_SHOULDER_DIST, 7'd1);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd8, 1'b0);
    send_pixel(8'd16, 1'b0);
    send_pixel(8'd23, 1'b1);
    drain_scores();
  endtask

  task automatic test_percent_extremes();
    // Above a hundred percent no peak can pass; bit 6 of the shoulder data drops.
    cfg_write(lhb_pkg::REG_SHOULDER_DIST, 7'h46);
    cfg_write(lhb_pkg::REG_MIN_PEAK_PCT, 7'h7F);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    drain_scores();

    cfg_write(lhb_pkg::REG_MIN_PEAK_PCT, 7'd100);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    drain_scores();

    // Exactly on the threshold passes.
    cfg_write(lhb_pkg::REG_MIN_PEAK_PCT, 7'd50);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    drain_scores();
  endtask

  // Hold the result side off for a long stretch while short frames keep
  // coming, so the result register and input queue fill and stall the pixels.
  task automatic test_backpressure();
    steady_flow = 1'b1;
    hold_req    = HOLD_OFF_CYCLES;
    repeat (12) send_frame(FRAME_TWO_HUMPS, $urandom_range(1, 4));
    steady_flow = 1'b0;
    drain_scores();
  endtask

  // Random frames over several settings, extremes among them; one phase runs
  // with no idling on either side.
  task automatic test_random_frames();
    logic [lhb_pkg::CFG_DATA_W-1:0] sd_plan  [RANDOM_PHASES];
    logic [lhb_pkg::CFG_DATA_W-1:0] pct_plan [RANDOM_PHASES];
    int                             sent, len, roll;
    frame_shape_t                   shape;
    sd_plan  = '{7'd6, 7'd1, 7'd31, 7'd32, lhb_pkg::CFG_DATA_W'($urandom), 7'd12, 7'd3,
                 lhb_pkg::CFG_DATA_W'($urandom)};
    pct_plan = '{7'd2, 7'd0, 7'd100, 7'd5, lhb_pkg::CFG_DATA_W'($urandom_range(30)), 7'd127,
                 7'd1, lhb_pkg::CFG_DATA_W'($urandom)};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(1)) begin
        cfg_write(lhb_pkg::REG_MIN_PEAK_PCT, pct_plan[ph]);
        cfg_write(lhb_pkg::REG_SHOULDER_DIST, sd_plan[ph]);
      end else begin
        cfg_write(lhb_pkg::REG_SHOULDER_DIST, sd_plan[ph]);
        cfg_write(lhb_pkg::REG_MIN_PEAK_PCT, pct_plan[ph]);
      end
      steady_flow = (ph == 2);
      sent = 0;
      while (sent < RANDOM_PIXELS / RANDOM_PHASES) begin
        roll = $urandom_range(99);
        if (roll < 75)      len = $urandom_range(1, 24);
        else if (roll < 95) len = $urandom_range(25, 80);
        else                len = $urandom_range(100, 250);
        // Trim the last frame of a phase to the pixel budget.
        if (len > RANDOM_PIXELS / RANDOM_PHASES - sent) len = RANDOM_PIXELS / RANDOM_PHASES - sent;
        roll = $urandom_range(99);
        if (roll < 55)      shape = FRAME_TWO_HUMPS;
        else if (roll < 70) shape = FRAME_ONE_HUMP;
        else if (roll < 85) shape = FRAME_NOISE;
        else                shape = FRAME_EXTREMES;
        send_frame(shape, len);
        sent += len;
      end
      steady_flow = 1'b0;
      drain_scores();
    end
  endtask

  initial begin
    // Drive every input from time zero; hold reset low before the tests start.
    rst_n             = 1'b0;
    pix_if.valid      = 1'b0;
    pix_if.pixel_luma = '0;
    pix_if.frame_end  = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    res_if.ready      = 1'b0;
    foreach (hist_count[i]) hist_count[i] = '0;
    frame_pixels = '0;
    shoulder_cfg = lhb_pkg::SD_RESET;
    min_pct_cfg  = lhb_pkg::PCT_RESET;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_spare_registers();
    test_shoulder_extremes();
    test_percent_extremes();
    test_backpressure();
    test_random_frames();

    drain_scores();
    if (pending_scores.size() != 0)
      report_mismatch("score words never delivered", 0, pending_scores.size());
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
